// ===== hw/rtl/spimbs_pkg.sv =====
package spimbs_pkg;

  // word widths
  localparam int unsigned DataBits  = 8;
  localparam int unsigned BitIdxW   = $clog2(DataBits);
  localparam int unsigned DivWidth  = 16;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InWidth   = 16;
  localparam int unsigned OutWidth  = 16;

  // configuration port
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = DivWidth;

  // reset value of the half period register
  localparam logic [DivWidth-1:0] HalfPeriodRst = DivWidth'(50);

  typedef enum logic [CfgIdxW-1:0] {
    RegEnable     = 2'd0,
    RegCpol       = 2'd1,
    RegCpha       = 2'd2,
    RegHalfPeriod = 2'd3
  } cfg_reg_e;

  // one result item as it is packed into m_axis_tdata
  typedef struct packed {
    logic [OutWidth-DataBits-6:0] pad;
    logic [DataBits-1:0]          rx_byte;
    logic                         rx_valid;
    logic                         busy_res;
    logic                         pins_driven;
    logic                         mosi;
    logic                         sck;
  } out_item_t;

endpackage

// ===== hw/rtl/spi_master_byte_shifter_top.sv =====
// channel   | dir | handshake                | payload
// ----------+-----+--------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/tready     | one clock tick: start_req, tx_byte, miso
// m_axis    | out | m_axis_tvalid/tready     | pin levels, busy, received byte
// cfg       | in  | cfg_we_i, no handshake   | enable, cpol, cpha, half_period_cycles
//
// one item in, one item out; the timing state advances once per accepted item
// the result of an item sits in the output register in the cycle after it is accepted
// a new item is taken every cycle while the output register is empty or being drained
// a stalled output holds its item and blocks input only for as long as it stalls
// reset clears all state: idle, sck and mosi low, registers at their defaults

module spi_master_byte_shifter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [spimbs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [spimbs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] start_req, [8:1] tx_byte, [9] miso, [15:10] zero
  input  logic [spimbs_pkg::InWidth-1:0]    s_axis_tdata,
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] sck, [1] mosi, [2] pins_driven, [3] busy_res, [4] rx_valid,
  // [12:5] rx_byte, [15:13] zero
  output logic [spimbs_pkg::OutWidth-1:0]   m_axis_tdata
);

  import spimbs_pkg::*;

  // configuration registers
  logic                 enable_q, cpol_q, cpha_q;
  logic [DivWidth-1:0]  half_q;

  // transfer state
  logic                 busy_q, busy_d;
  logic                 sample_q, sample_d;
  logic [BitIdxW-1:0]   bit_q, bit_d;
  logic [DataBits-1:0]  tx_q, tx_d;
  logic [DataBits-1:0]  rx_q, rx_d;
  logic [DivWidth-1:0]  cnt_q, cnt_d;
  logic                 sck_q, sck_d;
  logic                 mosi_q, mosi_d;

  // output register
  logic                 out_vld_q;
  out_item_t            out_q, out_d;

  // unpacked input item
  logic                 start_req;
  logic [DataBits-1:0]  tx_byte;
  logic                 miso;

  logic                 in_acc;
  logic [DivWidth-1:0]  period;
  logic [DivWidth-1:0]  cnt_dec;
  logic [BitIdxW-1:0]   bit_dec;
  logic                 done;

  assign start_req = s_axis_tdata[0];
  assign tx_byte   = s_axis_tdata[DataBits:1];
  assign miso      = s_axis_tdata[DataBits+1];

  // output register frees up when its item is taken
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign period  = (half_q == '0) ? DivWidth'(1) : half_q;
  assign cnt_dec = cnt_q - DivWidth'(1);
  assign bit_dec = bit_q - BitIdxW'(1);

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      cpol_q   <= 1'b0;
      cpha_q   <= 1'b0;
      half_q   <= HalfPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegEnable:     enable_q <= cfg_wdata_i[0];
        RegCpol:       cpol_q   <= cfg_wdata_i[0];
        RegCpha:       cpha_q   <= cfg_wdata_i[0];
        RegHalfPeriod: half_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // one tick of the shifter
  // ---------------------------------------------------------------------------
  always_comb begin
    busy_d   = busy_q;
    sample_d = sample_q;
    bit_d    = bit_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    cnt_d    = cnt_q;
    sck_d    = sck_q;
    mosi_d   = mosi_q;
    done     = 1'b0;

    if (!enable_q) begin
      // disabled: abort and release pins
      busy_d   = 1'b0;
      sample_d = 1'b0;
      mosi_d   = 1'b0;
      sck_d    = cpol_q;
      cnt_d    = '0;
    end else if (busy_q) begin
      cnt_d = cnt_dec;
      if (cnt_dec == '0) begin
        if (!sample_q) begin
          // end of setup half: sampling edge
          sck_d    = ~sck_q;
          if (miso) begin
            rx_d[bit_q] = 1'b1;
          end
          sample_d = 1'b1;
          cnt_d    = period;
        end else begin
          // end of sample half: back to idle level in mode 0/2
          if (!cpha_q) begin
            sck_d = ~sck_q;
          end
          if (bit_q == '0) begin
            busy_d   = 1'b0;
            sample_d = 1'b0;
            done     = 1'b1;
            bit_d    = BitIdxW'(DataBits - 1);
          end else begin
            // setup half of the next bit
            bit_d    = bit_dec;
            sample_d = 1'b0;
            if (cpha_q) begin
              sck_d = ~sck_d;
            end
            mosi_d   = tx_q[bit_dec];
            cnt_d    = period;
          end
        end
      end
    end else if (start_req) begin
      // start: this tick is the first of the top bit's setup half
      busy_d   = 1'b1;
      tx_d     = tx_byte;
      rx_d     = '0;
      bit_d    = BitIdxW'(DataBits - 1);
      sample_d = 1'b0;
      sck_d    = cpha_q ? ~cpol_q : cpol_q;
      mosi_d   = tx_byte[DataBits-1];
      cnt_d    = period;
    end

    if (!busy_d && enable_q) begin
      sck_d = cpol_q;
    end

    out_d             = '0;
    out_d.sck         = enable_q && sck_d;
    out_d.mosi        = enable_q && mosi_d;
    out_d.pins_driven = enable_q;
    out_d.busy_res    = busy_d;
    out_d.rx_valid    = done;
    out_d.rx_byte     = done ? rx_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      sample_q <= 1'b0;
      bit_q    <= BitIdxW'(DataBits - 1);
      tx_q     <= '0;
      rx_q     <= '0;
      cnt_q    <= '0;
      sck_q    <= 1'b0;
      mosi_q   <= 1'b0;
    end else if (in_acc) begin
      busy_q   <= busy_d;
      sample_q <= sample_d;
      bit_q    <= bit_d;
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      cnt_q    <= cnt_d;
      sck_q    <= sck_d;
      mosi_q   <= mosi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  // a running transfer always has ticks left in its current half
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("half counter empty during a transfer");

  // an accepted item always shows up in the output register
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_vld_q)
    else $error("accepted item lost");

  // completion and busy never coincide
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.rx_valid) |-> !out_q.busy_res)
    else $error("rx_valid while still busy");

  // released pins read low and carry no transfer
  a_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.pins_driven) |->
      (!out_q.sck && !out_q.mosi && !out_q.busy_res && !out_q.rx_valid))
    else $error("activity on released pins");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import spimbs_pkg::*;

  // random items after the directed part, and the long receiver hold-off in cycles
  localparam int unsigned RandItems  = 1300;
  localparam int unsigned HoldCycles = 48;
  localparam int unsigned HoldEvery  = 600;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [0] start_req, [8:1] tx_byte, [9] miso, [15:10] zero
  logic [InWidth-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [0] sck, [1] mosi, [2] pins_driven, [3] busy_res, [4] rx_valid,
  // [12:5] rx_byte, [15:13] zero
  logic [OutWidth-1:0] m_axis_tdata;

  // shadow of the spi engine: predicts the pin levels of every tick and
  // compares them with the result items in order
  class spi_pin_scoreboard;
    bit                enable;
    bit                cpol;
    bit                cpha;
    bit [DivWidth-1:0] half_period = HalfPeriodRst;
    bit                busy;
    bit                sample_half;
    bit [BitIdxW-1:0]  bit_idx = '1;
    bit [DataBits-1:0] tx_sr;
    bit [DataBits-1:0] rx_sr;
    bit [DivWidth-1:0] half_cnt;
    bit                sck_lvl;
    bit                mosi_lvl;
    out_item_t         expected_pins[$];
    int unsigned       errors;

    function void apply_reg(cfg_reg_e r, logic [CfgDataW-1:0] v);
      case (r)
        RegEnable:     enable = v[0];
        RegCpol:       cpol = v[0];
        RegCpha:       cpha = v[0];
        RegHalfPeriod: half_period = v[DivWidth-1:0];
        default: ;
      endcase
    endfunction

    // a zero half period counts as one tick
    function bit [DivWidth-1:0] half_ticks();
      return (half_period == '0) ? DivWidth'(1) : half_period;
    endfunction

    // setup half of the current bit: leading toggle for cpha 1, then mosi
    function void open_bit();
      sample_half = 1'b0;
      if (cpha) sck_lvl = ~sck_lvl;
      mosi_lvl = tx_sr[bit_idx];
      half_cnt = half_ticks();
    endfunction

    function void note_tick(bit start, bit [DataBits-1:0] txb, bit miso);
      out_item_t         want;
      bit                done;
      bit [DataBits-1:0] rxb;
      done = 1'b0;
      rxb  = '0;
      if (!enable) begin
        busy        = 1'b0;
        sample_half = 1'b0;
        mosi_lvl    = 1'b0;
        sck_lvl     = cpol;
        half_cnt    = '0;
      end else if (busy) begin
        half_cnt = half_cnt - 1'b1;
        if (half_cnt == '0) begin
          if (!sample_half) begin
            sck_lvl = ~sck_lvl;
            if (miso) rx_sr[bit_idx] = 1'b1;
            sample_half = 1'b1;
            half_cnt = half_ticks();
          end else begin
            if (!cpha) sck_lvl = ~sck_lvl;
            if (bit_idx == '0) begin
              busy        = 1'b0;
              sample_half = 1'b0;
              done        = 1'b1;
              rxb         = rx_sr;
              bit_idx     = '1;
            end else begin
              bit_idx = bit_idx - 1'b1;
              open_bit();
            end
          end
        end
      end else if (start) begin
        busy    = 1'b1;
        tx_sr   = txb;
        rx_sr   = '0;
        bit_idx = '1;
        sck_lvl = cpol;
        open_bit();
      end
      if (!busy && enable) sck_lvl = cpol;
      want             = '0;
      want.sck         = enable & sck_lvl;
      want.mosi        = enable & mosi_lvl;
      want.pins_driven = enable;
      want.busy_res    = busy;
      want.rx_valid    = done;
      want.rx_byte     = rxb;
      expected_pins.push_back(want);
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
      end
    endfunction

    function void check_pins(out_item_t got);
      out_item_t want;
      if (expected_pins.size() == 0) begin
        errors++;
        $display("%0t: result item expected none, got %0h", $time, got);
        return;
      end
      want = expected_pins.pop_front();
      compare_field("sck", want.sck, got.sck);
      compare_field("mosi", want.mosi, got.mosi);
      compare_field("pins_driven", want.pins_driven, got.pins_driven);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("rx_valid", want.rx_valid, got.rx_valid);
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("pad", want.pad, got.pad);
    endfunction
  endclass

  spi_pin_scoreboard sb = new();

  spi_master_byte_shifter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // result items are checked at the rising edge, before the flops update
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pins(m_axis_tdata);
  end

  // receiver: switches among random stall patterns; every so often,
  // while items are offered, it holds off long enough to back up the input
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned since_hold;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    since_hold = 0;
    forever begin
      @(negedge clk_i);
      since_hold++;
      if (hold_left == 0 && since_hold > HoldEvery && s_axis_tvalid) begin
        hold_left  = HoldCycles;
        since_hold = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 5) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // offer one tick and hold it until the block takes it; tvalid stays high
  // between back-to-back items
  task automatic send_tick(bit start, bit [DataBits-1:0] txb, bit miso);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, miso, txb, start};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(start, txb, miso);
  endtask

  task automatic pause_sender(int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // stop offering and wait until every expected result item has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.apply_reg(r, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random ticks in bursts with gaps; start_odds sets how often start is asked
  task automatic run_phase(int unsigned count, int unsigned start_odds);
    int unsigned burst;
    burst = $urandom_range(1, 24);
    for (int unsigned k = 0; k < count; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
        burst = $urandom_range(1, 24);
      end
      send_tick($urandom_range(0, start_odds - 1) == 0, 8'($urandom), 1'($urandom));
      burst--;
    end
  endtask

  initial begin
    int unsigned random_done;
    int unsigned pick;
    int unsigned count;
    logic [CfgDataW-1:0] hp;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // start while disabled must be ignored, pins stay released
    send_tick(1'b1, 8'hFF, 1'b1);
    send_tick(1'b0, 8'h00, 1'b0);
    wait_drained();

    // mode 0 with a zero half period, which runs as one tick per half
    write_reg(RegEnable, CfgDataW'(1));
    write_reg(RegHalfPeriod, '0);
    send_tick(1'b1, 8'hA5, 1'b1);
    // a start in mid transfer and one on the completing tick are both ignored
    for (int unsigned k = 0; k < 16; k++) begin
      send_tick(k == 6 || k == 15, 8'h00, 1'(k >> 1));
    end
    // idle again, so this start takes
    send_tick(1'b1, 8'h3C, 1'b0);
    wait_drained();

    // registers change in mid transfer: mode 3 and the longest half period
    write_reg(RegCpol, CfgDataW'(1));
    write_reg(RegCpha, CfgDataW'(1));
    write_reg(RegHalfPeriod, 16'hFFFF);
    send_tick(1'b0, 8'hFF, 1'b1);
    send_tick(1'b1, 8'h00, 1'b0);
    send_tick(1'b0, 8'h5A, 1'b1);
    wait_drained();

    // disabling aborts the transfer without rx_valid
    write_reg(RegEnable, '0);
    send_tick(1'b1, 8'h81, 1'b1);
    send_tick(1'b0, 8'h7E, 1'b0);

    // random phases; each reconfigures with nothing in flight, often while a
    // transfer is half done, so changes and aborts in mid transfer recur
    random_done = 0;
    while (random_done < RandItems) begin
      wait_drained();
      write_reg(RegEnable, CfgDataW'($urandom_range(0, 7) != 0));
      if ($urandom_range(0, 1)) write_reg(RegCpol, CfgDataW'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(RegCpha, CfgDataW'($urandom_range(0, 1)));
      pick = $urandom_range(0, 19);
      if (pick == 0) hp = '0;
      else if (pick == 1) hp = 16'hFFFF;
      else if (pick < 5) hp = CfgDataW'($urandom_range(5, 12));
      else hp = CfgDataW'($urandom_range(1, 4));
      if (pick < 5 || $urandom_range(0, 1)) write_reg(RegHalfPeriod, hp);
      // slow settings get a fixed phase length, they never finish a byte anyway
      count = (sb.half_period > 12) ? 200 : $urandom_range(40, 160);
      run_phase(count, $urandom_range(2, 8));
      random_done += count;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_pins.size() == 0) begin
      $display("spi_master_byte_shifter_top test passed");
    end else begin
      $display("spi_master_byte_shifter_top test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(400000 * 8);
    $display("spi_master_byte_shifter_top test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spimbs_pkg.sv
hw/rtl/spi_master_byte_shifter_top.sv
tb/testbench.sv
